>>> src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation-to-quaternion block
// Fixed-point formats, channel payloads and the data carried between cells.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Number format: signed DATA_W bits with FRAC_W fraction bits (Q2.14)
  localparam int DATA_W = 16;
  localparam int FRAC_W = 14;

  // Diagonal sums and radicands (three entries plus one)
  localparam int SUM_W  = DATA_W + 2;
  // Numerators: sum or difference of two entries
  localparam int NUM_W  = DATA_W + 1;
  // Non-negative radicand value before scaling
  localparam int VAL_W  = DATA_W + 1;
  // Scaled radicand, padded to an even width for the two-bit root steps
  localparam int RAD_W  = VAL_W + FRAC_W;
  localparam int RAD_E  = RAD_W + (RAD_W % 2);
  localparam int ROOT_W = RAD_E / 2;
  localparam int REM_W  = ROOT_W + 3;
  // Dividend and shifted divisor width in the divider cells
  localparam int DIV_W  = ROOT_W + 1 + DATA_W;
  localparam int LANES  = 4;

  // Epsilon 1e-6 in Q format, truncated
  localparam int EPS_Q  = (2 ** FRAC_W) / 1000000;

  // Output lanes
  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_Z = 2'd2;
  localparam logic [1:0] LANE_W = 2'd3;

  typedef enum logic [1:0] {
    PATH_TRACE = 2'd0,
    PATH_X     = 2'd1,
    PATH_Y     = 2'd2,
    PATH_Z     = 2'd3
  } path_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] right_x;
    logic signed [DATA_W-1:0] right_y;
    logic signed [DATA_W-1:0] right_z;
    logic signed [DATA_W-1:0] up_x;
    logic signed [DATA_W-1:0] up_y;
    logic signed [DATA_W-1:0] up_z;
    logic signed [DATA_W-1:0] fwd_x;
    logic signed [DATA_W-1:0] fwd_y;
    logic signed [DATA_W-1:0] fwd_z;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] quat_w;
    logic                     radicand_clamped;
    path_t                    chosen_path;
  } out_t;

  // Data carried through the square-root cells
  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] num;
    path_t                       path;
    logic                        clamped;
    logic [RAD_E-1:0]            rad;
    logic [REM_W-1:0]            rem;
    logic [ROOT_W-1:0]           root;
  } sq_t;

  // One quotient lane in the divider cells
  typedef struct packed {
    logic              neg;
    logic              zero;
    logic              ovf;
    logic [DIV_W-1:0]  rem;
    logic [DIV_W-1:0]  den;
    logic [DATA_W-1:0] quo;
  } lane_t;

  // Data carried through the divider cells
  typedef struct packed {
    path_t                  path;
    logic                   clamped;
    logic [ROOT_W-1:0]      root;
    lane_t [LANES-1:0]      lane;
  } dv_t;

  // Lane that takes the half root for a given path
  function automatic logic [1:0] half_lane(path_t p);
    logic [1:0] l;
    case (p)
      PATH_TRACE: l = LANE_W;
      PATH_X:     l = LANE_X;
      PATH_Y:     l = LANE_Y;
      PATH_Z:     l = LANE_Z;
      default:    l = LANE_W;
    endcase
    return l;
  endfunction

endpackage

>>> src/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top: rotation basis to quaternion converter
//
//   Channel | Ports                         | Payload
//   input   | in_valid, in_ready, in_data   | rmq_pkg::in_t, nine Q2.14 entries
//   result  | out_valid, out_ready, out_data| rmq_pkg::out_t, quaternion + flags
//
// One matrix is taken per cycle unless a stall holds the chain. The chain is
// a setup cell, one cell per root bit (16), divider setup, one cell per
// quotient bit (16) and output. Each cell holds its own valid bit, so bubbles
// close up under a stall and input transfers continue, while empty cells
// remain, behind a waiting result register. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rmq_pkg::out_t out_data
);

  localparam int RB = rmq_pkg::ROOT_W;
  localparam int QB = rmq_pkg::DATA_W;

  logic         sq_vld [RB+1];
  logic         sq_rdy [RB+1];
  rmq_pkg::sq_t sq_dat [RB+1];
  logic         dv_vld [QB+1];
  logic         dv_rdy [QB+1];
  rmq_pkg::dv_t dv_dat [QB+1];

  rmq_front u_front (
    .clk, .rst_n,
    .vld_i (in_valid), .rdy_o (in_ready), .data_i (in_data),
    .vld_o (sq_vld[0]), .rdy_i (sq_rdy[0]), .data_o (sq_dat[0])
  );

  // Root chain, most significant digit first
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk, .rst_n,
      .vld_i (sq_vld[k]), .rdy_o (sq_rdy[k]), .data_i (sq_dat[k]),
      .vld_o (sq_vld[k+1]), .rdy_i (sq_rdy[k+1]), .data_o (sq_dat[k+1])
    );
  end

  rmq_div_prep u_prep (
    .clk, .rst_n,
    .vld_i (sq_vld[RB]), .rdy_o (sq_rdy[RB]), .data_i (sq_dat[RB]),
    .vld_o (dv_vld[0]), .rdy_i (dv_rdy[0]), .data_o (dv_dat[0])
  );

  // Quotient chain, most significant bit first
  for (genvar k = 0; k < QB; k++) begin : g_div
    rmq_div_cell #(.BIT(QB - 1 - k)) u_cell (
      .clk, .rst_n,
      .vld_i (dv_vld[k]), .rdy_o (dv_rdy[k]), .data_i (dv_dat[k]),
      .vld_o (dv_vld[k+1]), .rdy_i (dv_rdy[k+1]), .data_o (dv_dat[k+1])
    );
  end

  rmq_back u_back (
    .clk, .rst_n,
    .vld_i (dv_vld[QB]), .rdy_o (dv_rdy[QB]), .data_i (dv_dat[QB]),
    .vld_o (out_valid), .rdy_i (out_ready), .data_o (out_data)
  );

endmodule

>>> src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front: path selection and radicand setup
// Forms the trace, picks the path, clamps the radicand and routes numerators.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  output logic         rdy_o,
  input  rmq_pkg::in_t data_i,
  output logic         vld_o,
  input  logic         rdy_i,
  output rmq_pkg::sq_t data_o
);

  localparam int SW = rmq_pkg::SUM_W;
  localparam int NW = rmq_pkg::NUM_W;
  localparam int VW = rmq_pkg::VAL_W;
  localparam logic signed [SW-1:0] ONE_Q = SW'(1) << rmq_pkg::FRAC_W;
  localparam logic signed [SW-1:0] EPS_V = SW'(rmq_pkg::EPS_Q);

  logic signed [SW-1:0] rx, uy, fz, trc, rad;
  logic signed [NW-1:0] dx, dy, dz, sp, sq, ss;
  logic [VW-1:0]        val;
  logic                 trace_path, clamp;
  rmq_pkg::path_t       path;
  rmq_pkg::sq_t         nxt;
  logic                 vld_r;
  rmq_pkg::sq_t         data_r;

  assign rx  = SW'(data_i.right_x);
  assign uy  = SW'(data_i.up_y);
  assign fz  = SW'(data_i.fwd_z);
  assign trc = rx + uy + fz + ONE_Q;
  assign trace_path = trc > EPS_V;

  assign dx = NW'(data_i.up_z) - NW'(data_i.fwd_y);
  assign dy = NW'(data_i.fwd_x) - NW'(data_i.right_z);
  assign dz = NW'(data_i.right_y) - NW'(data_i.up_x);
  assign sp = NW'(data_i.up_x) + NW'(data_i.right_y);
  assign sq = NW'(data_i.fwd_x) + NW'(data_i.right_z);
  assign ss = NW'(data_i.fwd_y) + NW'(data_i.up_z);

  // Pick the trace path, else the dominant axis with the tie rules
  always_comb begin
    if (trace_path) begin
      path = rmq_pkg::PATH_TRACE;
    end else if (rx >= uy) begin
      if (rx > fz) path = rmq_pkg::PATH_X;
      else if (uy > fz) path = rmq_pkg::PATH_Y;
      else path = rmq_pkg::PATH_Z;
    end else begin
      if (uy >= fz) path = rmq_pkg::PATH_Y;
      else if (rx > fz) path = rmq_pkg::PATH_X;
      else path = rmq_pkg::PATH_Z;
    end
  end

  // Form the radicand and route numerators to their lanes
  always_comb begin
    nxt = '0;
    case (path)
      rmq_pkg::PATH_X: rad = rx + ONE_Q - uy - fz;
      rmq_pkg::PATH_Y: rad = uy + ONE_Q - rx - fz;
      rmq_pkg::PATH_Z: rad = fz + ONE_Q - rx - uy;
      default:         rad = trc;
    endcase
    clamp = !trace_path && rad[SW-1];
    val   = clamp ? '0 : rad[VW-1:0];
    case (path)
      rmq_pkg::PATH_X: begin
        nxt.num[rmq_pkg::LANE_Y] = sp;
        nxt.num[rmq_pkg::LANE_Z] = sq;
        nxt.num[rmq_pkg::LANE_W] = ss;
      end
      rmq_pkg::PATH_Y: begin
        nxt.num[rmq_pkg::LANE_X] = sp;
        nxt.num[rmq_pkg::LANE_Z] = ss;
        nxt.num[rmq_pkg::LANE_W] = sq;
      end
      rmq_pkg::PATH_Z: begin
        nxt.num[rmq_pkg::LANE_X] = sq;
        nxt.num[rmq_pkg::LANE_Y] = ss;
        nxt.num[rmq_pkg::LANE_W] = sp;
      end
      default: begin
        nxt.num[rmq_pkg::LANE_X] = dx;
        nxt.num[rmq_pkg::LANE_Y] = dy;
        nxt.num[rmq_pkg::LANE_Z] = dz;
      end
    endcase
    nxt.path    = path;
    nxt.clamped = clamp;
    nxt.rad     = rmq_pkg::RAD_E'({val, {rmq_pkg::FRAC_W{1'b0}}});
  end

  assign rdy_o = !vld_r || rdy_i;

  // Advance when this cell is empty or the next cell can take the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> src/rmq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one root digit
// Brings down two radicand bits and resolves one bit of the integer root.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  output logic         rdy_o,
  input  rmq_pkg::sq_t data_i,
  output logic         vld_o,
  input  logic         rdy_i,
  output rmq_pkg::sq_t data_o
);

  localparam int RB = rmq_pkg::ROOT_W;
  localparam int MW = rmq_pkg::REM_W;
  localparam int RE = rmq_pkg::RAD_E;

  logic [MW-1:0] rem2, trial;
  logic          ge;
  rmq_pkg::sq_t  nxt;
  logic          vld_r;
  rmq_pkg::sq_t  data_r;

  // Trial subtract of (4*root + 1) from the extended remainder
  always_comb begin
    rem2  = {data_i.rem[MW-3:0], data_i.rad[RE-1:RE-2]};
    trial = {1'b0, data_i.root, 2'b01};
    ge    = rem2 >= trial;
    nxt      = data_i;
    nxt.rad  = {data_i.rad[RE-3:0], 2'b00};
    nxt.rem  = ge ? (rem2 - trial) : rem2;
    nxt.root = {data_i.root[RB-2:0], ge};
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> src/rmq_div_prep.sv
// ----------------------------------------------------------------------------
// rmq_div_prep: divider setup
// Splits numerators into sign and magnitude, forms dividends and flags overflow.
// ----------------------------------------------------------------------------
module rmq_div_prep (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  output logic         rdy_o,
  input  rmq_pkg::sq_t data_i,
  output logic         vld_o,
  input  logic         rdy_i,
  output rmq_pkg::dv_t data_o
);

  localparam int NW = rmq_pkg::NUM_W;
  localparam int DW = rmq_pkg::DIV_W;

  rmq_pkg::dv_t nxt;
  logic [NW-1:0] mag [rmq_pkg::LANES];
  logic          vld_r;
  rmq_pkg::dv_t  data_r;

  // Dividend (|n| << F) + r over divisor 2r; overflow when quotient needs extra bits
  always_comb begin
    nxt         = '0;
    nxt.path    = data_i.path;
    nxt.clamped = data_i.clamped;
    nxt.root    = data_i.root;
    for (int i = 0; i < rmq_pkg::LANES; i++) begin
      nxt.lane[i].neg  = data_i.num[i][NW-1];
      mag[i]           = data_i.num[i][NW-1] ? (NW'(0) - data_i.num[i]) : data_i.num[i];
      nxt.lane[i].zero = mag[i] == '0;
      nxt.lane[i].den  = DW'({data_i.root, 1'b0});
      nxt.lane[i].rem  = DW'({mag[i], {rmq_pkg::FRAC_W{1'b0}}}) + DW'(data_i.root);
      nxt.lane[i].ovf  = nxt.lane[i].rem >= (nxt.lane[i].den << rmq_pkg::DATA_W);
    end
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> src/rmq_div_cell.sv
// ----------------------------------------------------------------------------
// rmq_div_cell: one quotient bit
// Resolves quotient bit BIT in every lane by a restoring subtract.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
  parameter int BIT = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  output logic         rdy_o,
  input  rmq_pkg::dv_t data_i,
  output logic         vld_o,
  input  logic         rdy_i,
  output rmq_pkg::dv_t data_o
);

  localparam int DW = rmq_pkg::DIV_W;

  logic [DW-1:0] sub [rmq_pkg::LANES];
  logic          ge  [rmq_pkg::LANES];
  rmq_pkg::dv_t  nxt;
  logic          vld_r;
  rmq_pkg::dv_t  data_r;

  always_comb begin
    nxt = data_i;
    for (int i = 0; i < rmq_pkg::LANES; i++) begin
      sub[i] = data_i.lane[i].den << BIT;
      ge[i]  = data_i.lane[i].rem >= sub[i];
      nxt.lane[i].rem      = ge[i] ? (data_i.lane[i].rem - sub[i]) : data_i.lane[i].rem;
      nxt.lane[i].quo[BIT] = ge[i];
    end
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> src/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back: result assembly and output register
// Applies signs, saturates, places the half root and holds the result.
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  output logic          rdy_o,
  input  rmq_pkg::dv_t  data_i,
  output logic          vld_o,
  input  logic          rdy_i,
  output rmq_pkg::out_t data_o
);

  localparam int W  = rmq_pkg::DATA_W;
  localparam int HW = rmq_pkg::ROOT_W + 1;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [HW-1:0]  hr;
  logic [W-1:0]   hr_sat;
  logic [W-1:0]   res [rmq_pkg::LANES];
  logic [1:0]     hl;
  rmq_pkg::out_t  nxt;
  logic           vld_r;
  rmq_pkg::out_t  data_r;

  // Half root, rounded half up, saturated
  assign hr     = (HW'(data_i.root) + HW'(1)) >> 1;
  assign hr_sat = (hr > HW'(SMAX)) ? SMAX : hr[W-1:0];
  assign hl     = rmq_pkg::half_lane(data_i.path);

  always_comb begin
    for (int i = 0; i < rmq_pkg::LANES; i++) begin
      if (2'(i) == hl) begin
        res[i] = hr_sat;
      end else if (data_i.lane[i].zero) begin
        res[i] = '0;
      end else if (data_i.lane[i].ovf) begin
        res[i] = data_i.lane[i].neg ? SMIN : SMAX;
      end else if (data_i.lane[i].neg) begin
        res[i] = (data_i.lane[i].quo > SMIN) ? SMIN : (W'(0) - data_i.lane[i].quo);
      end else begin
        res[i] = (data_i.lane[i].quo > SMAX) ? SMAX : data_i.lane[i].quo;
      end
    end
    nxt.quat_x           = res[rmq_pkg::LANE_X];
    nxt.quat_y           = res[rmq_pkg::LANE_Y];
    nxt.quat_z           = res[rmq_pkg::LANE_Z];
    nxt.quat_w           = res[rmq_pkg::LANE_W];
    nxt.radicand_clamped = data_i.clamped;
    nxt.chosen_path      = data_i.path;
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> src/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_port_checks: port-level checks for the converter
// Watches the result channel and the meaning of its flags.
// ----------------------------------------------------------------------------
module rmq_port_checks (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rmq_pkg::out_t out_data
);

  // Nothing emerges in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The trace path never clamps
  a_trace_noclamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chosen_path == rmq_pkg::PATH_TRACE |-> !out_data.radicand_clamped)
    else $error("clamp flagged on trace path");

  // On the trace path the half root lane, w, is never negative
  a_half_root_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chosen_path == rmq_pkg::PATH_TRACE
      |-> !out_data.quat_w[rmq_pkg::DATA_W-1])
    else $error("negative w on trace path");

  // Input handshake never backs up when the pipe is drained and output free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_valid && $past(!in_valid) && $past(rst_n) |-> in_ready)
    else $error("input stalled with nothing held in output");

endmodule

bind rotation_matrix_to_quaternion_top rmq_port_checks u_rmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/rmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker: result checker for the rotation-to-quaternion converter
// Watches both channels, computes the expected quaternion for every input
// transfer and compares each result transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module rmq_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  rmq_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rmq_pkg::out_t out_data,
  output int            fail_count,
  output int            pending,
  output int            result_count
);

  localparam int     FW    = rmq_pkg::FRAC_W;
  localparam int     DW    = rmq_pkg::DATA_W;
  localparam longint QONE  = 64'sd1 <<< FW;
  localparam longint QMAX  = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint QMIN  = -QMAX - 1;
  localparam longint QEPS  = QONE / 1000000;

  rmq_pkg::out_t quat_queue[$];
  int   path_hits[4];
  int   clamp_hits;

  initial begin
    fail_count   = 0;
    result_count = 0;
    clamp_hits   = 0;
    foreach (path_hits[i]) path_hits[i] = 0;
  end

  assign pending = quat_queue.size();

  // Integer square root, truncated
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint half_of_root(longint unsigned r);
    return clip(longint'((r + 1) >> 1));
  endfunction

  // n / (2r) in Q format, nearest with ties away, saturated
  function automatic longint scaled_quotient(longint n, longint unsigned r);
    logic neg;
    longint unsigned mag;
    longint unsigned q;
    neg = n < 0;
    mag = neg ? longint'(-n) : n;
    if (mag == 0) return 0;
    if (r == 0) return neg ? QMIN : QMAX;
    q = ((mag << FW) + r) / (r << 1);
    if (neg) begin
      if (q > longint'(QMAX) + 1) return QMIN;
      return -longint'(q);
    end
    if (q > QMAX) return QMAX;
    return longint'(q);
  endfunction

  function automatic rmq_pkg::out_t quat_of_basis(rmq_pkg::in_t m);
    longint rx, ry, rz, ux, uy, uz, fx, fy, fz;
    longint tr, rad, p, q, s;
    longint unsigned r;
    longint qx, qy, qz, qw;
    rmq_pkg::path_t pth;
    rmq_pkg::out_t o;
    rx = m.right_x; ry = m.right_y; rz = m.right_z;
    ux = m.up_x;    uy = m.up_y;    uz = m.up_z;
    fx = m.fwd_x;   fy = m.fwd_y;   fz = m.fwd_z;
    tr = rx + uy + fz + QONE;
    p  = ux + ry; q = fx + rz; s = fy + uz;
    o.radicand_clamped = 1'b0;
    if (tr > QEPS) begin
      r   = int_sqrt(longint'(tr) << FW);
      qw  = half_of_root(r);
      qx  = scaled_quotient(uz - fy, r);
      qy  = scaled_quotient(fx - rz, r);
      qz  = scaled_quotient(ry - ux, r);
      pth = rmq_pkg::PATH_TRACE;
    end else begin
      if (rx >= uy) begin
        if (rx > fz) pth = rmq_pkg::PATH_X;
        else if (uy > fz) pth = rmq_pkg::PATH_Y;
        else pth = rmq_pkg::PATH_Z;
      end else begin
        if (uy >= fz) pth = rmq_pkg::PATH_Y;
        else if (rx > fz) pth = rmq_pkg::PATH_X;
        else pth = rmq_pkg::PATH_Z;
      end
      case (pth)
        rmq_pkg::PATH_X: rad = rx + QONE - uy - fz;
        rmq_pkg::PATH_Y: rad = uy + QONE - rx - fz;
        default:         rad = fz + QONE - rx - uy;
      endcase
      if (rad < 0) begin
        rad = 0;
        o.radicand_clamped = 1'b1;
      end
      r = int_sqrt(longint'(rad) << FW);
      case (pth)
        rmq_pkg::PATH_X: begin
          qx = half_of_root(r); qy = scaled_quotient(p, r);
          qz = scaled_quotient(q, r); qw = scaled_quotient(s, r);
        end
        rmq_pkg::PATH_Y: begin
          qx = scaled_quotient(p, r); qy = half_of_root(r);
          qz = scaled_quotient(s, r); qw = scaled_quotient(q, r);
        end
        default: begin
          qx = scaled_quotient(q, r); qy = scaled_quotient(s, r);
          qz = half_of_root(r); qw = scaled_quotient(p, r);
        end
      endcase
    end
    o.quat_x = qx[DW-1:0];
    o.quat_y = qy[DW-1:0];
    o.quat_z = qz[DW-1:0];
    o.quat_w = qw[DW-1:0];
    o.chosen_path = pth;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d",
             result_count, what, got, want);
    fail_count++;
  endtask

  // Predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    rmq_pkg::out_t want;
    if (rst_n && in_valid && in_ready) quat_queue.push_back(quat_of_basis(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (quat_queue.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = quat_queue.pop_front();
        if (out_data.quat_x !== want.quat_x)
          report_mismatch("quat_x", out_data.quat_x, want.quat_x);
        if (out_data.quat_y !== want.quat_y)
          report_mismatch("quat_y", out_data.quat_y, want.quat_y);
        if (out_data.quat_z !== want.quat_z)
          report_mismatch("quat_z", out_data.quat_z, want.quat_z);
        if (out_data.quat_w !== want.quat_w)
          report_mismatch("quat_w", out_data.quat_w, want.quat_w);
        if (out_data.radicand_clamped !== want.radicand_clamped)
          report_mismatch("radicand_clamped", out_data.radicand_clamped,
                          want.radicand_clamped);
        if (out_data.chosen_path !== want.chosen_path)
          report_mismatch("chosen_path", out_data.chosen_path, want.chosen_path);
        path_hits[want.chosen_path]++;
        if (want.radicand_clamped) clamp_hits++;
      end
      result_count++;
    end
  end

  task automatic report_leftovers();
    if (quat_queue.size() != 0) report_mismatch("results never arrived", 0,
                                                quat_queue.size());
    $display("Checked %0d results: trace %0d, x axis %0d, y axis %0d, z axis %0d,",
             result_count, path_hits[0], path_hits[1], path_hits[2], path_hits[3]);
    $display("clamped radicand %0d, under mixed sender gaps and receiver stalls",
             clamp_hits);
  endtask

endmodule

>>> tb/rotation_matrix_to_quaternion_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top_tb: stimulus and verdict
// Sends directed and random bases through the converter under
// several idling phases and a long receiver hold-off; the checker predicts
// and compares every quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top_tb;

  localparam int LATENCY = 35;
  localparam int S1 = 16384;   // 1.0 in Q2.14
  localparam int DW = rmq_pkg::DATA_W;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rmq_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  rmq_pkg::out_t out_data;
  int   fail_count;
  int   pending;
  int   result_count;
  int   send_idle_pct;
  int   stall_pct;
  logic hold_off;

  rotation_matrix_to_quaternion_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rmq_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("rotation_matrix_to_quaternion_top_tb: errors");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic rmq_pkg::in_t basis_of(int v[9]);
    rmq_pkg::in_t m;
    m.right_x = DW'(v[0]); m.right_y = DW'(v[1]); m.right_z = DW'(v[2]);
    m.up_x    = DW'(v[3]); m.up_y    = DW'(v[4]); m.up_z    = DW'(v[5]);
    m.fwd_x   = DW'(v[6]); m.fwd_y   = DW'(v[7]); m.fwd_z   = DW'(v[8]);
    return m;
  endfunction

  // Random item: entries in [-1, 1], some raw noise, some biased to the axis paths and to diagonal ties
  function automatic rmq_pkg::in_t random_basis();
    int v[9];
    int kind;
    kind = $urandom_range(9);
    foreach (v[i]) v[i] = $signed($urandom_range(2 * S1)) - S1;
    case (kind)
      0, 1: foreach (v[i]) v[i] = $signed(16'($urandom));
      2: begin
        v[0] = -S1 + $urandom_range(40); v[4] = -S1 + $urandom_range(40);
        v[8] = $urandom_range(1) ? S1 : -S1;
      end
      3, 4, 5: begin
        // force trace low, unless the clip below lifts it, so an axis formula is taken
        v[0] = $signed($urandom_range(2 * S1)) - S1;
        v[4] = $signed($urandom_range(2 * S1)) - S1;
        v[8] = -S1 - v[0] - v[4] - $urandom_range(S1);
        if (v[8] < -32768) v[8] = -32768;
      end
      6: begin
        // ties on the diagonal
        v[0] = -S1 / 2 - $urandom_range(3);
        v[4] = $urandom_range(1) ? v[0] : v[0] - 1;
        v[8] = $urandom_range(1) ? v[0] : v[4];
      end
      default: ;
    endcase
    return basis_of(v);
  endfunction

  // Offer one item; drop valid only for an idle gap
  task automatic send(rmq_pkg::in_t m);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stream several items back to back; valid stays high between them
  task automatic send_burst(int n);
    for (int k = 0; k < n; k++) begin
      in_valid <= 1'b1;
      in_data  <= random_basis();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int dir[20][9];
    int pcts[4][2];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off      = 1'b0;
    pcts = '{'{0, 0}, '{56, 0}, '{0, 56}, '{34, 34}};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, half turns, extremes, ties
    dir = '{
      '{S1, 0, 0, 0, S1, 0, 0, 0, S1},
      '{S1, 0, 0, 0, -S1, 0, 0, 0, -S1},
      '{-S1, 0, 0, 0, S1, 0, 0, 0, -S1},
      '{-S1, 0, 0, 0, -S1, 0, 0, 0, S1},
      '{-S1, 5, 7, -3, -S1, 9, 1, -2, -S1},
      '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-8192, 100, 200, 300, -8192, 400, 500, 600, -8192},
      '{-8192, 1, 2, 3, -8192, 4, 5, 6, -8193},
      '{-8193, 1, 2, 3, -8192, 4, 5, 6, -8192},
      '{-8192, 1, 2, 3, -8193, 4, 5, 6, -8192},
      '{-16000, 0, 0, 0, -16000, 0, 0, 0, 32767},
      '{-32768, 0, 0, 0, 32767, 0, 0, 0, -32768},
      '{32767, 0, 0, 0, -32768, 0, 0, 0, -32768},
      '{-S1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-S1 + 1, 0, 0, 0, 0, 0, 0, 0, -1},
      '{0, 11585, 0, -11585, 0, 0, 0, 0, S1},
      '{-S1, 32767, 32767, 32767, -S1, 32767, 32767, 32767, -S1}
    };
    foreach (dir[i]) send(basis_of(dir[i]));
    in_valid <= 1'b0;
    drain();

    // Random phases under each idling mix, with a no-idle stretch each time
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pcts[ph][0];
      stall_pct     = pcts[ph][1];
      for (int k = 0; k < 250; k++) send(random_basis());
      send_burst(20);
      drain();
    end

    // Long receiver hold-off while the sender keeps offering items
    hold_off = 1'b1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      send_burst(100);
    join

    drain();
    repeat (LATENCY + 5) @(posedge clk);
    chk.report_leftovers();
    if (fail_count == 0) $display("rotation_matrix_to_quaternion_top_tb: clean");
    else $display("rotation_matrix_to_quaternion_top_tb: errors");
    $finish;
  end

endmodule

>>> sim.f
src/rmq_pkg.sv
src/rmq_front.sv
src/rmq_sqrt_cell.sv
src/rmq_div_prep.sv
src/rmq_div_cell.sv
src/rmq_back.sv
src/rotation_matrix_to_quaternion_top.sv
src/rmq_checker.sv
tb/rmq_checker.sv
tb/rotation_matrix_to_quaternion_top_tb.sv
